// ----- rtl/echo_pulse_range_capture_defines.svh -----
// Assertion macros shared by the echo pulse range capture RTL.
// No dependencies; files that check their logic include this header by name.
`ifndef ECHO_PULSE_RANGE_CAPTURE_DEFINES_SVH
`define ECHO_PULSE_RANGE_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS
`define EPR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("echo pulse range capture: check failed");
`define EPR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("echo pulse range capture: check failed");
`else
`define EPR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define EPR_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/epr_pkg.sv -----
// Types and constants of the echo pulse range capture block.
// No dependencies; imported by every module of the block.
package epr_pkg;

  localparam int DATA_W      = 32;
  localparam int CLK_W       = 21;
  localparam int DIV_W       = CLK_W + 1;
  localparam int DIST_W      = 16;
  localparam int CH_FIELD_W  = 3;
  localparam int PAIR_W      = 2;
  localparam int MODE_W      = 2;
  localparam int CNT_W       = $clog2(DATA_W);
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DIST_W - CH_FIELD_W;

  localparam logic [DATA_W-1:0] SOUND_MM_PER_MS = 32'd343;
  localparam logic [CLK_W-1:0]  CLOCK_KHZ_RST   = 21'd180000;
  localparam logic [DIST_W-1:0] MIN_DIST_RST    = 16'd20;
  localparam logic [DIST_W-1:0] MAX_DIST_RST    = 16'd4000;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_KHZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_EDGE    = 2'd0,
    MODE_TRIGGER = 2'd1,
    MODE_PROCESS = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RISING = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_MUL,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic edge_wr;
    logic trig_clr;
    logic span_ld;
    logic mul_ld;
    logic div_start;
    logic emit;
    logic hi;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/epr_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on epr_pkg and the assertion macros header.
`include "echo_pulse_range_capture_defines.svh"

module epr_div import epr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W:0]    trial;
  logic              fits;

  // The quotient register also holds the dividend bits not yet shifted in.
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(trial - {1'b0, div_r}) : DIV_W'(trial);
      quo_nxt = {quo_r[DATA_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  `EPR_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, done_r && (div_r != '0), rem_r < div_r)

endmodule

// ----- rtl/epr_dp.sv -----
// Datapath: configuration registers, per-channel capture state, span,
// multiply, divider, range check and output register. Depends on epr_pkg,
// epr_div and the assertion macros header.
`include "echo_pulse_range_capture_defines.svh"

module epr_dp import epr_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CLK_W-1:0]       cfg_data
);

  localparam int CH_W = $clog2(CHANNELS);

  logic [CH_FIELD_W-1:0] in_ch;
  logic [PAIR_W-1:0]     in_pair;
  logic                  in_level;
  logic [DATA_W-1:0]     in_stamp;

  logic [CLK_W-1:0]  clock_khz_r;
  logic [DIST_W-1:0] min_dist_r;
  logic [DIST_W-1:0] max_dist_r;

  logic [DATA_W-1:0] rise_r  [CHANNELS];
  logic [DATA_W-1:0] rise_nxt[CHANNELS];
  logic [DATA_W-1:0] fall_r  [CHANNELS];
  logic [DATA_W-1:0] fall_nxt[CHANNELS];
  phase_t            phase_r  [CHANNELS];
  phase_t            phase_nxt[CHANNELS];

  logic [PAIR_W-1:0] pair_r;
  logic [CH_W-1:0]   sel;
  logic [DATA_W-1:0] span_r;
  logic              done_r;
  logic [DATA_W-1:0] prod_r;

  logic              div_busy;
  logic              div_done;
  logic [DATA_W-1:0] quo;
  logic              in_range;

  logic                  out_valid_r;
  logic [CH_FIELD_W-1:0] out_ch_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic                  out_ok_r;
  logic                  out_last_r;

  assign in_ch    = in_tdata[2:0];
  assign in_pair  = in_tdata[4:3];
  assign in_level = in_tdata[5];
  assign in_stamp = in_tdata[37:6];

  // Configuration is taken in any cycle; a write to an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_khz_r <= CLOCK_KHZ_RST;
      min_dist_r  <= MIN_DIST_RST;
      max_dist_r  <= MAX_DIST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CLOCK_KHZ: clock_khz_r <= cfg_data;
        REG_MIN_DIST:  min_dist_r  <= cfg_data[DIST_W-1:0];
        REG_MAX_DIST:  max_dist_r  <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Each channel decodes its own edge and trigger updates, so no entry is
  // read at a second, event-chosen address.
  always_comb begin
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    phase_nxt = phase_r;
    for (int i = 0; i < CHANNELS; i++) begin
      if (cmd.edge_wr && (int'(in_ch) == i)) begin
        if (in_level) begin
          rise_nxt[i]  = in_stamp;
          phase_nxt[i] = PH_RISING;
        end else if (phase_r[i] == PH_RISING) begin
          fall_nxt[i]  = in_stamp;
          phase_nxt[i] = PH_DONE;
        end
      end
      if (cmd.trig_clr && (int'(in_pair) == (i >> 1))) begin
        phase_nxt[i] = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_r[i]  <= '0;
        fall_r[i]  <= '0;
        phase_r[i] <= PH_IDLE;
      end
    end else begin
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign sel = CH_W'({pair_r, cmd.hi});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pair_r <= in_pair;
    end
    if (cmd.span_ld) begin
      span_r <= fall_r[sel] - rise_r[sel];
      done_r <= (phase_r[sel] == PH_DONE);
    end
    if (cmd.mul_ld) begin
      prod_r <= DATA_W'(span_r * SOUND_MM_PER_MS);
    end
  end

  epr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  ({clock_khz_r, 1'b0}),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // A zero clock means a zero divisor, which never gives a valid reading.
  assign in_range = done_r && (clock_khz_r != '0)
                 && (quo >= DATA_W'(min_dist_r)) && (quo <= DATA_W'(max_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_ch_r   <= CH_FIELD_W'({pair_r, cmd.hi});
      out_dist_r <= in_range ? quo[DIST_W-1:0] : '0;
      out_ok_r   <= in_range;
      out_last_r <= cmd.hi;
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_dist_r, out_ch_r};
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

  `EPR_ASSERT_IMP(a_emit_into_free_slot, clk, rst_n, cmd.emit, sts.out_free)
  `EPR_ASSERT_IMP(a_invalid_reads_zero, clk, rst_n, out_valid_r && !out_ok_r, out_dist_r == '0)
  `EPR_ASSERT_IMP(a_last_is_odd_channel, clk, rst_n, out_valid_r && out_last_r, out_ch_r[0])

endmodule

// ----- rtl/epr_ctrl.sv -----
// Controller state machine: takes input words, decodes the event and steps the datapath
// through span, multiply, divide and emit. Depends on epr_pkg and the assertion macros header.
`include "echo_pulse_range_capture_defines.svh"

module epr_ctrl import epr_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [PAIR_W-1:0] in_pair,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;
  logic   hi_r, hi_nxt;
  logic   accept;
  logic   pair_ok;

  // Both channels of the pair must exist.
  assign pair_ok = (int'({in_pair, 1'b0}) + 1) < CHANNELS;
  assign accept  = in_tvalid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    hi_nxt    = hi_r;
    unique case (state_r)
      S_IDLE: begin
        hi_nxt = 1'b0;
        if (accept && (in_mode == MODE_PROCESS) && pair_ok) begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          hi_nxt    = !hi_r;
          state_nxt = hi_r ? S_IDLE : S_SPAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.accept    = accept;
    cmd.edge_wr   = accept && (in_mode == MODE_EDGE);
    cmd.trig_clr  = accept && (in_mode == MODE_TRIGGER) && pair_ok;
    cmd.span_ld   = (state_r == S_SPAN);
    cmd.mul_ld    = (state_r == S_MUL);
    cmd.div_start = (state_r == S_START);
    cmd.emit      = (state_r == S_EMIT) && sts.out_free;
    cmd.hi        = hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hi_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hi_r    <= hi_nxt;
    end
  end

  `EPR_ASSERT_IMP(a_idle_divider_quiet, clk, rst_n, state_r == S_IDLE, !sts.div_busy)

endmodule

// ----- rtl/echo_pulse_range_capture.sv -----
// Top level of the echo pulse range capture block.
// Depends on epr_pkg, epr_ctrl and epr_dp.
//
//   Port group  Direction  Carries
//   in_*        slave      one event word: mode, channel, pair, level, timestamp
//   out_*       master     one range word per channel of a processed pair
//   cfg_*       slave      writes to the clock rate and the minimum and maximum range
//
// Edge and trigger events are taken while the controller is idle. A process event
// steps each of its two channels in turn through span, multiply, divider start,
// the radix-2 divider and emit; no new word is taken until both are emitted. An
// emit waits while the output register is full. A single divider serves every
// channel. The second result is parked in the output register while the next
// word is taken. Reset is synchronous and clears all capture state.

module echo_pulse_range_capture import epr_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] channel, [4:3] pair, [5] level, [37:6] timestamp, [39:38] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] out_channel, [18:3] range in mm, [23:19] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] valid_res
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CLK_W-1:0]       cfg_data
);

  cmd_t cmd;
  sts_t sts;

  epr_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_pair   (in_tdata[4:3]),
    .sts       (sts),
    .cmd       (cmd)
  );

  epr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

// ----- bench/epr_range_checker.sv -----
// Checker for the echo pulse range capture block: follows the event, result and
// register channels, predicts every distance word and compares it with the block.
// Depends on epr_pkg only.
`timescale 1ns / 100ps

module epr_range_checker import epr_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [2:0] channel, [4:3] pair, [5] level, [37:6] timestamp, [39:38] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] out_channel, [18:3] range in mm, [23:19] zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] valid_res
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CLK_W-1:0]       cfg_data,
  output int                     fail_count,
  output int                     readings_due,
  output int                     readings_checked
);

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [DIST_W-1:0]     distance;
    logic                  in_range;
    logic                  is_last;
  } reading_t;

  logic [DATA_W-1:0] rise_stamp [CHANNELS];
  logic [DATA_W-1:0] fall_stamp [CHANNELS];
  phase_t            capture    [CHANNELS];
  logic [CLK_W-1:0]  clock_khz;
  logic [DIST_W-1:0] min_mm;
  logic [DIST_W-1:0] max_mm;
  reading_t          expected_readings [$];
  int                fails = 0;
  int                checked = 0;

  // Distance of one channel as the block must report it right now.
  function automatic reading_t predict_reading(input int ch, input logic is_last);
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] product;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] quot;
    reading_t r;
    r.channel  = ch[CH_FIELD_W-1:0];
    r.distance = '0;
    r.in_range = 1'b0;
    r.is_last  = is_last;
    divisor = {{(DATA_W-CLK_W-1){1'b0}}, clock_khz, 1'b0};
    if (capture[ch] == PH_DONE && divisor != '0) begin
      span    = fall_stamp[ch] - rise_stamp[ch];
      product = span * SOUND_MM_PER_MS;
      quot    = product / divisor;
      if (quot >= DATA_W'(min_mm) && quot <= DATA_W'(max_mm)) begin
        r.in_range = 1'b1;
        r.distance = quot[DIST_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic take_event(input logic [MODE_W-1:0] mode, input logic [IN_TDATA_W-1:0] word);
    int ch;
    int base;
    logic rising;
    logic [DATA_W-1:0] stamp;
    ch     = int'(word[2:0]);
    base   = 2 * int'(word[4:3]);
    rising = word[5];
    stamp  = word[37:6];
    case (mode)
      MODE_EDGE: if (ch < CHANNELS) begin
        if (rising) begin
          rise_stamp[ch] = stamp;
          capture[ch]    = PH_RISING;
        end else if (capture[ch] == PH_RISING) begin
          fall_stamp[ch] = stamp;
          capture[ch]    = PH_DONE;
        end
      end
      MODE_TRIGGER: if (base + 1 < CHANNELS) begin
        capture[base]     = PH_IDLE;
        capture[base + 1] = PH_IDLE;
      end
      MODE_PROCESS: if (base + 1 < CHANNELS) begin
        expected_readings.push_back(predict_reading(base, 1'b0));
        expected_readings.push_back(predict_reading(base + 1, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int exp, input int act);
    if (exp != act) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
    end
  endtask

  task automatic check_reading();
    reading_t exp;
    if (expected_readings.size() == 0) begin
      fails++;
      $display("%0t: distance word with none expected, actual channel %0d distance %0d",
               $time, out_tdata[2:0], out_tdata[18:3]);
    end else begin
      exp = expected_readings.pop_front();
      checked++;
      compare_field("channel", exp.channel, out_tdata[2:0]);
      compare_field("distance", exp.distance, out_tdata[18:3]);
      compare_field("range flag", exp.in_range, out_tuser);
      compare_field("last flag", exp.is_last, out_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_khz = CLOCK_KHZ_RST;
      min_mm    = MIN_DIST_RST;
      max_mm    = MAX_DIST_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_stamp[i] = '0;
        fall_stamp[i] = '0;
        capture[i]    = PH_IDLE;
      end
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLOCK_KHZ: clock_khz = cfg_data;
          REG_MIN_DIST:  min_mm    = cfg_data[DIST_W-1:0];
          REG_MAX_DIST:  max_mm    = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_event(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_reading();
    end
    readings_due     <= expected_readings.size();
    fail_count       <= fails;
    readings_checked <= checked;
  end

endmodule

// ----- bench/echo_pulse_range_capture_tb.sv -----
// Testbench top for the echo pulse range capture block: drives event words and
// register writes, applies back-pressure and gives the verdict.
// Depends on epr_pkg, echo_pulse_range_capture and epr_range_checker.
`timescale 1ns / 100ps

module echo_pulse_range_capture_tb;
  import epr_pkg::*;

  localparam int CHANNELS       = 8;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_WORDS   = 650;
  localparam int SETTINGS_COUNT = 7;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CLK_W-1:0]       cfg_data   = '0;

  int fail_count;
  int readings_due;
  int readings_checked;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int words_sent  = 0;
  int random_start;
  int goal;
  int lo;

  // Current register values, used only to aim spans at the distance window.
  logic [CLK_W-1:0]  set_clk = CLOCK_KHZ_RST;
  logic [DIST_W-1:0] set_min = MIN_DIST_RST;
  logic [DIST_W-1:0] set_max = MAX_DIST_RST;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  echo_pulse_range_capture #(.CHANNELS(CHANNELS)) dut (.*);

  epr_range_checker #(.CHANNELS(CHANNELS)) u_checker (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d distance words outstanding.",
               readings_due);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [2:0] ch,
                           input logic [1:0] p, input logic lvl, input logic [31:0] stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, stamp, lvl, p, ch};
    do @(posedge clk); while (!in_tready);
    if (mode != MODE_UNUSED) words_sent++;
  endtask

  task automatic echo_at(input int ch, input logic lvl, input logic [31:0] stamp);
    send_word(MODE_EDGE, 3'(ch), 2'($urandom), lvl, stamp);
  endtask

  task automatic pair_cmd(input logic [MODE_W-1:0] mode, input int p);
    send_word(mode, 3'($urandom), 2'(p), 1'($urandom), $urandom);
  endtask

  // Echo length that lands on distance d under the present clock setting.
  function automatic logic [31:0] span_for(input int d);
    logic [63:0] num;
    num = 64'(d) * 64'(set_clk) * 64'd2 + 64'd342;
    return 32'(num / 64'd343);
  endfunction

  function automatic logic [31:0] pick_span();
    int d;
    int hi;
    int floor_d;
    if (set_clk == '0 || $urandom_range(9) == 0) return $urandom;
    floor_d = (set_min > 50) ? set_min - 50 : 0;
    hi      = (set_max > 65485) ? 65535 : set_max + 50;
    if (floor_d > hi) begin
      floor_d = 0;
      hi      = 65535;
    end
    case ($urandom_range(5))
      0:       d = set_min;
      1:       d = set_max;
      2:       d = (set_min > 0) ? set_min - 1 : 0;
      3:       d = set_max + 1;
      default: d = $urandom_range(hi, floor_d);
    endcase
    return span_for(d);
  endfunction

  // One measurement cycle of a pair; a broken one loses edges or restarts one.
  task automatic measure_pair(input int p, input logic broken);
    int a;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] s0;
    logic [31:0] s1;
    logic swap;
    a    = 2 * p;
    t0   = $urandom;
    t1   = $urandom;
    s0   = pick_span();
    s1   = pick_span();
    swap = 1'($urandom);
    if ($urandom_range(4) != 0) pair_cmd(MODE_TRIGGER, p);
    if (!broken || $urandom_range(2) != 0) echo_at(a, 1'b1, t0);
    if (!broken || $urandom_range(2) != 0) echo_at(a + 1, 1'b1, t1);
    if (swap) echo_at(a + 1, 1'b0, t1 + s1);
    if (!broken || $urandom_range(2) != 0) echo_at(a, 1'b0, t0 + s0);
    if (!swap) echo_at(a + 1, 1'b0, t1 + s1);
    if (broken && $urandom_range(1) == 0) echo_at(a + $urandom_range(1), 1'b1, $urandom);
    pair_cmd(MODE_PROCESS, p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_ranges(input logic [CLK_W-1:0] khz, input logic [DIST_W-1:0] dmin,
                            input logic [DIST_W-1:0] dmax);
    set_clk = khz;
    set_min = dmin;
    set_max = dmax;
    write_reg(REG_CLOCK_KHZ, khz);
    write_reg(REG_MIN_DIST, CLK_W'(dmin));
    write_reg(REG_MAX_DIST, CLK_W'(dmax));
    cfg_valid <= 1'b0;
  endtask

  // Drain all pending distance words, then give trailing events time to settle.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic directed_events();
    pair_cmd(MODE_PROCESS, 0);
    echo_at(0, 1'b0, 32'd50);
    echo_at(0, 1'b1, 32'd0);
    echo_at(0, 1'b1, 32'd100);
    echo_at(0, 1'b0, 32'd100 + span_for(1000));
    echo_at(1, 1'b1, 32'hFFFF_FFF0);
    echo_at(1, 1'b0, 32'hFFFF_FFF0 + span_for(62));
    echo_at(0, 1'b0, 32'd7);
    pair_cmd(MODE_PROCESS, 0);
    pair_cmd(MODE_TRIGGER, 0);
    pair_cmd(MODE_PROCESS, 0);
    echo_at(0, 1'b1, 32'd500);
    pair_cmd(MODE_PROCESS, 0);
    send_word(MODE_UNUSED, 3'h7, 2'h3, 1'b1, 32'hFFFF_FFFF);
    echo_at(7, 1'b1, 32'd0);
    echo_at(7, 1'b0, 32'hFFFF_FFFF);
    echo_at(6, 1'b1, 32'd5);
    echo_at(6, 1'b0, 32'd5 + span_for(set_min - 1));
    pair_cmd(MODE_PROCESS, 3);
    echo_at(2, 1'b1, 32'h8000_0000);
    echo_at(2, 1'b0, 32'h8000_0000 + span_for(set_min));
    echo_at(3, 1'b1, 32'h1234_5678);
    echo_at(3, 1'b0, 32'h1234_5678 + span_for(set_max));
    pair_cmd(MODE_PROCESS, 1);
    echo_at(4, 1'b1, 32'h5555_5555);
    echo_at(4, 1'b0, 32'h5555_5555 + span_for(set_max + 1));
    echo_at(5, 1'b1, 32'hAAAA_AAAA);
    pair_cmd(MODE_PROCESS, 2);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 20;
    rx_idle_pct = 50;
    directed_events();
    random_start = words_sent;
    for (int ph = 0; ph < SETTINGS_COUNT; ph++) begin
      wait_quiet();
      case (ph)
        0: set_ranges(21'd1, 16'd0, 16'hFFFF);
        1: set_ranges(21'd2000000, 16'd0, 16'hFFFF);
        2: set_ranges(21'd0, 16'd20, 16'd4000);
        3: begin
          lo = $urandom_range(30000);
          set_ranges(21'($urandom_range(200000, 1000)), 16'(lo),
                     16'($urandom_range(65535, lo)));
        end
        4: set_ranges(21'd50000, 16'd3000, 16'd1000);
        5: set_ranges(21'($urandom_range(2000000, 1)), 16'($urandom), 16'($urandom));
        default: set_ranges(CLOCK_KHZ_RST, MIN_DIST_RST, MAX_DIST_RST);
      endcase
      goal = random_start + (ph + 1) * RANDOM_WORDS / SETTINGS_COUNT;
      while (words_sent < goal) begin
        if (words_sent - random_start < RANDOM_WORDS / 3) begin
          tx_idle_pct = 20;
          rx_idle_pct = 50;
        end else if (words_sent - random_start < 2 * RANDOM_WORDS / 3) begin
          tx_idle_pct = 50;
          rx_idle_pct = 20;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        case ($urandom_range(19))
          0, 1: send_word(2'($urandom_range(3)), 3'($urandom), 2'($urandom),
                          1'($urandom), $urandom);
          2, 3, 4: measure_pair($urandom_range(3), 1'b1);
          default: measure_pair($urandom_range(3), 1'b0);
        endcase
      end
    end
    wait_quiet();
    $display("Covered %0d event words over %0d register settings plus the reset values.",
             words_sent, SETTINGS_COUNT);
    $display("Checked %0d distance words with %0d mismatches.", readings_checked, fail_count);
    if (fail_count == 0 && readings_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
